@@ rtl/dhcpote_pkg.sv @@
package dhcpote_pkg;

    localparam int OPTIONS_BYTES = 256;
    localparam int AW = $clog2(OPTIONS_BYTES);
    // Pointers hold positions past the end plus one full entry span.
    localparam int PW = ((AW > 9) ? AW : 9) + 2;

    localparam logic [7:0] END_MARK = 8'hFF;

    typedef logic [PW-1:0] t_ptr;

    localparam t_ptr AREA_SIZE = t_ptr'(OPTIONS_BYTES);

    typedef enum logic [1:0] {
        REQ_INIT  = 2'd0,
        REQ_SET   = 2'd1,
        REQ_VALUE = 2'd2,
        REQ_READ  = 2'd3
    } t_req_type;

    typedef enum logic [1:0] {
        STS_OK         = 2'd0,
        STS_TAG_REJECT = 2'd1,
        STS_NO_ROOM    = 2'd2,
        STS_UNEXPECTED = 2'd3
    } t_status;

    typedef struct packed {
        t_req_type  req_type;
        logic [7:0] tag;
        logic [7:0] length;
        logic [7:0] data_byte;
        logic [7:0] read_index;
    } t_req;

    typedef struct packed {
        t_status    status;
        logic [7:0] read_byte;
    } t_rsp;

endpackage

@@ rtl/dhcp_option_tag_editor.sv @@
// Channel   Direction  Handshake                     Payload
// request   in         i_req_valid / o_req_stall     i_req (dhcpote_pkg::t_req)
// response  out        o_rsp_valid / i_rsp_stall     o_rsp (dhcpote_pkg::t_rsp)
//
// Init and value requests are answered in the cycle after they are taken, a read
// request by way of ST_RD. A set request walks the area through one read port and
// one write port of the option memory: it reads each entry's tag and length,
// moves an entry behind a deleted one byte by byte, pads the tail after a delete,
// and finds the end of the walk to place the new tag and length.
// Reset is synchronous; per-byte valid bits make the area read as 255 at once.
// A response waiting under i_rsp_stall holds the next request off.
module dhcp_option_tag_editor (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_req_valid,
    output logic                o_req_stall,
    input  dhcpote_pkg::t_req   i_req,
    output logic                o_rsp_valid,
    input  logic                i_rsp_stall,
    output dhcpote_pkg::t_rsp   o_rsp
);
    import dhcpote_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD,
        ST_TAG_RD,
        ST_TAG_DT,
        ST_LEN_DT,
        ST_COPY,
        ST_TAIL,
        ST_PLACE,
        ST_PLACE2
    } t_state;

    // option memory and per-byte valid bits
    logic [7:0]            mem [OPTIONS_BYTES];
    logic [OPTIONS_BYTES-1:0] r_vld;
    logic [7:0]            r_rdata;
    logic                  r_rvld;
    logic                  r_roob;

    logic                  mem_we;
    logic [AW-1:0]         mem_wa;
    logic [7:0]            mem_wd;
    logic                  mem_re;
    t_ptr                  rd_addr;
    logic                  clear_all;
    logic [7:0]            area_byte;

    t_state     r_state, n_state;
    t_state     r_ret, n_ret;
    t_ptr       r_d, n_d;
    t_ptr       r_k, n_k;
    t_ptr       r_pos, n_pos;
    t_ptr       r_cnt, n_cnt;
    t_ptr       r_wa, n_wa;
    logic       r_pend, n_pend;
    logic [7:0] r_etag, n_etag;
    logic [7:0] r_tag, n_tag;
    logic [7:0] r_len, n_len;
    t_ptr       r_fill, n_fill;
    logic [7:0] r_await, n_await;
    logic       r_ovld, n_ovld;
    t_rsp       r_rsp, n_rsp;

    logic       in_acc;
    t_ptr       span;

    assign o_req_stall = (r_state != ST_IDLE) || (r_ovld && i_rsp_stall);
    assign in_acc      = i_req_valid && !o_req_stall;
    assign o_rsp_valid = r_ovld;
    assign o_rsp       = r_rsp;

    assign area_byte = (r_roob || !r_rvld) ? END_MARK : r_rdata;
    assign span      = t_ptr'(area_byte) + t_ptr'(2);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rdata <= mem[rd_addr[AW-1:0]];
            r_rvld  <= r_vld[rd_addr[AW-1:0]];
            r_roob  <= (rd_addr >= AREA_SIZE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (clear_all) begin
            r_vld <= '0;
        end else if (mem_we) begin
            r_vld[mem_wa] <= 1'b1;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_ret     = r_ret;
        n_d       = r_d;
        n_k       = r_k;
        n_pos     = r_pos;
        n_cnt     = r_cnt;
        n_wa      = r_wa;
        n_pend    = r_pend;
        n_etag    = r_etag;
        n_tag     = r_tag;
        n_len     = r_len;
        n_fill    = r_fill;
        n_await   = r_await;
        n_ovld    = (r_ovld && i_rsp_stall);
        n_rsp     = r_rsp;
        mem_we    = 1'b0;
        mem_wa    = '0;
        mem_wd    = END_MARK;
        mem_re    = 1'b0;
        rd_addr   = '0;
        clear_all = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    case (i_req.req_type)
                        REQ_INIT: begin
                            clear_all = 1'b1;
                            n_fill    = '0;
                            n_await   = '0;
                            n_ovld    = 1'b1;
                            n_rsp     = '{STS_OK, 8'h00};
                        end
                        REQ_VALUE: begin
                            n_ovld = 1'b1;
                            if (r_await != '0 && r_fill < AREA_SIZE) begin
                                mem_we  = 1'b1;
                                mem_wa  = r_fill[AW-1:0];
                                mem_wd  = i_req.data_byte;
                                n_fill  = r_fill + t_ptr'(1);
                                n_await = r_await - 8'd1;
                                n_rsp   = '{STS_OK, 8'h00};
                            end else begin
                                n_await = '0;
                                n_rsp   = '{STS_UNEXPECTED, 8'h00};
                            end
                        end
                        REQ_SET: begin
                            n_await = '0;
                            if (i_req.tag == 8'h00 || i_req.tag == END_MARK) begin
                                n_ovld = 1'b1;
                                n_rsp  = '{STS_TAG_REJECT, 8'h00};
                            end else begin
                                n_tag   = i_req.tag;
                                n_len   = i_req.length;
                                n_d     = '0;
                                n_k     = '0;
                                n_state = ST_TAG_RD;
                            end
                        end
                        REQ_READ: begin
                            mem_re  = 1'b1;
                            rd_addr = t_ptr'(i_req.read_index);
                            n_state = ST_RD;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_RD: begin
                n_ovld  = 1'b1;
                n_rsp   = '{STS_OK, area_byte};
                n_state = ST_IDLE;
            end
            ST_TAG_RD: begin
                if (r_d >= AREA_SIZE) begin
                    n_state = ST_TAIL;
                end else begin
                    mem_re  = 1'b1;
                    rd_addr = r_d + r_k;
                    n_state = ST_TAG_DT;
                end
            end
            ST_TAG_DT: begin
                if (area_byte == END_MARK) begin
                    n_state = ST_TAIL;
                end else begin
                    n_etag  = area_byte;
                    mem_re  = 1'b1;
                    rd_addr = r_d + r_k + t_ptr'(1);
                    n_state = ST_LEN_DT;
                end
            end
            ST_LEN_DT: begin
                if (r_etag == r_tag) begin
                    // drop the entry; one that reaches the end clears the rest
                    if (r_d + span >= AREA_SIZE) begin
                        n_k     = AREA_SIZE;
                        n_state = ST_TAIL;
                    end else begin
                        n_k     = r_k + span;
                        n_state = ST_TAG_RD;
                    end
                end else if (r_k == '0) begin
                    n_d     = r_d + span;
                    n_state = ST_TAG_RD;
                end else begin
                    n_cnt   = span;
                    n_pend  = 1'b0;
                    n_ret   = ST_TAG_RD;
                    n_state = ST_COPY;
                end
            end
            ST_COPY: begin
                // move bytes forward by r_k; a read beyond the area yields pad
                if (r_pend && r_wa < AREA_SIZE) begin
                    mem_we = 1'b1;
                    mem_wa = r_wa[AW-1:0];
                    mem_wd = area_byte;
                end
                if (r_cnt != '0) begin
                    mem_re  = 1'b1;
                    rd_addr = r_d + r_k;
                    n_wa    = r_d;
                    n_d     = r_d + t_ptr'(1);
                    n_cnt   = r_cnt - t_ptr'(1);
                    n_pend  = 1'b1;
                end else begin
                    n_pend  = 1'b0;
                    n_state = r_ret;
                end
            end
            ST_TAIL: begin
                n_pos = r_d;
                if (r_d >= AREA_SIZE || r_k == '0) begin
                    n_state = ST_PLACE;
                end else begin
                    n_cnt   = AREA_SIZE - r_d;
                    n_pend  = 1'b0;
                    n_ret   = ST_PLACE;
                    n_state = ST_COPY;
                end
            end
            ST_PLACE: begin
                if (r_len == 8'h00) begin
                    n_ovld  = 1'b1;
                    n_rsp   = '{STS_OK, 8'h00};
                    n_state = ST_IDLE;
                end else if (r_pos + t_ptr'(2) + t_ptr'(r_len) > AREA_SIZE) begin
                    n_ovld  = 1'b1;
                    n_rsp   = '{STS_NO_ROOM, 8'h00};
                    n_state = ST_IDLE;
                end else begin
                    mem_we  = 1'b1;
                    mem_wa  = r_pos[AW-1:0];
                    mem_wd  = r_tag;
                    n_state = ST_PLACE2;
                end
            end
            ST_PLACE2: begin
                mem_we  = 1'b1;
                mem_wa  = AW'(r_pos + t_ptr'(1));
                mem_wd  = r_len;
                n_fill  = r_pos + t_ptr'(2);
                n_await = r_len;
                n_ovld  = 1'b1;
                n_rsp   = '{STS_OK, 8'h00};
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ret   <= ST_IDLE;
            r_pend  <= 1'b0;
            r_fill  <= '0;
            r_await <= '0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_pend  <= n_pend;
            r_fill  <= n_fill;
            r_await <= n_await;
            r_ovld  <= n_ovld;
        end
        r_d    <= n_d;
        r_k    <= n_k;
        r_pos  <= n_pos;
        r_cnt  <= n_cnt;
        r_wa   <= n_wa;
        r_etag <= n_etag;
        r_tag  <= n_tag;
        r_len  <= n_len;
        r_rsp  <= n_rsp;
    end

    a_no_rw_same_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_we && mem_re) |-> (t_ptr'(mem_wa) != rd_addr))
        else $error("write and read hit the same option byte");

    a_fill_in_area: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill + t_ptr'(r_await)) <= AREA_SIZE)
        else $error("awaited value bytes run past the area");

    a_busy_no_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !r_ovld)
        else $error("response pending while a request is in work");

    a_read_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_req.req_type == REQ_READ) |=> ##1 o_rsp_valid)
        else $error("read response missing two cycles after request");

endmodule
